FILE: rtl/vrp_pkg.sv
// ----------------------------------------------------------------------------
// vrp_pkg
// Shared types, codes and helpers for the version reply parser.
// ----------------------------------------------------------------------------
package vrp_pkg;

	// Field widths
	localparam int BYTE_W      = 8;
	localparam int VER_W       = 16;
	localparam int TYPE_W      = 2;
	localparam int CFG_IDX_W   = 1;
	localparam int SKIP_W      = 3;
	localparam int OUT_FIELD_W = VER_W + TYPE_W + 1 + BYTE_W;
	localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

	// Register reset values
	localparam logic [VER_W-1:0] MIN_M_RESET = 16'd10201;
	localparam logic [VER_W-1:0] MIN_P_RESET = 16'd11101;

	// Characters of interest
	localparam logic [BYTE_W-1:0] CH_DASH = 8'h2D;
	localparam logic [BYTE_W-1:0] CH_R    = 8'h52;
	localparam logic [BYTE_W-1:0] CH_M    = 8'h4D;

	// Skip lengths after the minor terminator (dash terminator adds four)
	localparam logic [SKIP_W-1:0] SKIP_PLAIN = 3'd3;
	localparam logic [SKIP_W-1:0] SKIP_DASH  = 3'd7;

	// Module type codes
	localparam logic [TYPE_W-1:0] TYPE_M = 2'd0;
	localparam logic [TYPE_W-1:0] TYPE_P = 2'd1;
	localparam logic [TYPE_W-1:0] TYPE_R = 2'd2;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MIN_M = 1'b0,
		REG_MIN_P = 1'b1
	} cfg_reg_t;

	// Parser phases
	typedef enum logic [3:0] {
		PH_MAJ_START = 4'd0,
		PH_MAJ_DIG   = 4'd1,
		PH_MIN_START = 4'd2,
		PH_MIN_DIG   = 4'd3,
		PH_DROP      = 4'd4,
		PH_TYPE1     = 4'd5,
		PH_TYPE_DROP = 4'd6,
		PH_TYPE2     = 4'd7,
		PH_TO_DASH   = 4'd8,
		PH_TAIL      = 4'd9
	} phase_t;

	// One finished reply
	typedef struct packed {
		logic              valid;
		logic [VER_W-1:0]  version;
		logic [TYPE_W-1:0] module_type;
		logic              new_commands;
		logic [BYTE_W-1:0] end_byte;
	} result_t;

	function automatic logic is_digit(input logic [BYTE_W-1:0] c);
		return (c >= 8'h30) && (c <= 8'h39);
	endfunction

	function automatic logic is_alnum(input logic [BYTE_W-1:0] c);
		return is_digit(c) || ((c >= 8'h41) && (c <= 8'h5A)) ||
			((c >= 8'h61) && (c <= 8'h7A));
	endfunction

endpackage

FILE: rtl/vrp_in_stage.sv
// ----------------------------------------------------------------------------
// vrp_in_stage
// Input register: captures one received byte per transaction.
// ----------------------------------------------------------------------------
module vrp_in_stage (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [vrp_pkg::BYTE_W-1:0] s_tdata,
	input  logic                       take,      // parser consumes the held byte
	output logic                       byte_valid,
	output logic [vrp_pkg::BYTE_W-1:0] rx_byte
);

	logic                       valid_s1;
	logic [vrp_pkg::BYTE_W-1:0] byte_s1;

	// Accept whenever the slot is empty or being drained
	assign s_tready   = !valid_s1 || take;
	assign byte_valid = valid_s1;
	assign rx_byte    = byte_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
		end
	end

endmodule

FILE: rtl/vrp_parse.sv
// ----------------------------------------------------------------------------
// vrp_parse
// Parser state and single-step update: one byte advances the state machine,
// and the ending byte of a reply produces a result.
// ----------------------------------------------------------------------------
module vrp_parse (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        step,
	input  logic [vrp_pkg::BYTE_W-1:0]  rx_byte,
	input  logic [vrp_pkg::VER_W-1:0]   min_m,
	input  logic [vrp_pkg::VER_W-1:0]   min_p,
	output vrp_pkg::result_t            result
);

	vrp_pkg::phase_t               phase_q, phase_d, ph_eff;
	logic                          negative_q, negative_d;
	logic [vrp_pkg::VER_W-1:0]     major_q, major_d;
	logic [vrp_pkg::VER_W-1:0]     minor_q, minor_d;
	logic [vrp_pkg::SKIP_W-1:0]    skip_q, skip_d, skip_dec;
	logic [vrp_pkg::TYPE_W-1:0]    type_q, type_d;
	logic                          digit, alnum, dash;
	logic [3:0]                    dval;
	logic [vrp_pkg::VER_W-1:0]     major_x10, minor_x10;
	logic [vrp_pkg::VER_W-1:0]     major_sgn, minor_sgn, major_x100;
	logic                          done;

	// Byte classification
	assign digit = vrp_pkg::is_digit(rx_byte);
	assign alnum = vrp_pkg::is_alnum(rx_byte);
	assign dash  = (rx_byte == vrp_pkg::CH_DASH);
	assign dval  = rx_byte[3:0];

	// Unused phase codes behave as major number start
	assign ph_eff = (phase_q > vrp_pkg::PH_TAIL) ? vrp_pkg::PH_MAJ_START : phase_q;

	// Accumulators: times ten as shifts and adds, wrapping at 16 bits
	assign major_x10  = {major_q[12:0], 3'b000} + {major_q[14:0], 1'b0} + {12'd0, dval};
	assign minor_x10  = {minor_q[12:0], 3'b000} + {minor_q[14:0], 1'b0} + {12'd0, dval};
	assign major_sgn  = negative_q ? (~major_q + 16'd1) : major_q;
	assign minor_sgn  = negative_q ? (~minor_q + 16'd1) : minor_q;
	assign major_x100 = {major_sgn[9:0], 6'd0} + {major_sgn[10:0], 5'd0} +
		{major_sgn[13:0], 2'd0};
	assign skip_dec   = skip_q - 3'd1;
	assign done       = (ph_eff == vrp_pkg::PH_TAIL) && !alnum;

	// Next phase
	always_comb begin
		phase_d = phase_q;
		case (ph_eff)
			vrp_pkg::PH_MAJ_DIG: begin
				if (digit) phase_d = vrp_pkg::PH_MAJ_DIG;
				else       phase_d = vrp_pkg::PH_MIN_START;
			end
			vrp_pkg::PH_MIN_START: begin
				if (dash || digit) phase_d = vrp_pkg::PH_MIN_DIG;
				else               phase_d = vrp_pkg::PH_DROP;
			end
			vrp_pkg::PH_MIN_DIG: begin
				if (digit) phase_d = vrp_pkg::PH_MIN_DIG;
				else       phase_d = vrp_pkg::PH_DROP;
			end
			vrp_pkg::PH_DROP: begin
				if (skip_dec == 3'd0) phase_d = vrp_pkg::PH_TYPE1;
			end
			vrp_pkg::PH_TYPE1: begin
				if (rx_byte == vrp_pkg::CH_R) phase_d = vrp_pkg::PH_TO_DASH;
				else                          phase_d = vrp_pkg::PH_TYPE_DROP;
			end
			vrp_pkg::PH_TYPE_DROP: phase_d = vrp_pkg::PH_TYPE2;
			vrp_pkg::PH_TYPE2:     phase_d = vrp_pkg::PH_TO_DASH;
			vrp_pkg::PH_TO_DASH: begin
				if (dash) phase_d = vrp_pkg::PH_TAIL;
			end
			vrp_pkg::PH_TAIL: begin
				if (!alnum) phase_d = vrp_pkg::PH_MAJ_START;
			end
			default: begin // major number start
				if (dash || digit) phase_d = vrp_pkg::PH_MAJ_DIG;
				else               phase_d = vrp_pkg::PH_MIN_START;
			end
		endcase
	end

	// Datapath and result
	always_comb begin
		negative_d = negative_q;
		major_d    = major_q;
		minor_d    = minor_q;
		skip_d     = skip_q;
		type_d     = type_q;
		case (ph_eff)
			vrp_pkg::PH_MAJ_DIG: begin
				if (digit) begin
					major_d = major_x10;
				end else begin
					major_d    = major_x100;
					negative_d = 1'b0;
					minor_d    = '0;
				end
			end
			vrp_pkg::PH_MIN_START, vrp_pkg::PH_MIN_DIG: begin
				if ((ph_eff == vrp_pkg::PH_MIN_START) && dash) begin
					negative_d = 1'b1;
				end else if (digit) begin
					minor_d = minor_x10;
				end else begin
					major_d    = major_q + minor_sgn;
					negative_d = 1'b0;
					skip_d     = dash ? vrp_pkg::SKIP_DASH : vrp_pkg::SKIP_PLAIN;
				end
			end
			vrp_pkg::PH_DROP: skip_d = skip_dec;
			vrp_pkg::PH_TYPE1: begin
				if (rx_byte == vrp_pkg::CH_R) type_d = vrp_pkg::TYPE_R;
			end
			vrp_pkg::PH_TYPE2: begin
				type_d = (rx_byte == vrp_pkg::CH_M) ? vrp_pkg::TYPE_M : vrp_pkg::TYPE_P;
			end
			vrp_pkg::PH_TYPE_DROP, vrp_pkg::PH_TO_DASH: ;
			vrp_pkg::PH_TAIL: begin
				if (!alnum) begin
					negative_d = 1'b0;
					major_d    = '0;
					minor_d    = '0;
					skip_d     = '0;
					type_d     = vrp_pkg::TYPE_M;
				end
			end
			default: begin // major number start
				if (dash) begin
					negative_d = 1'b1;
				end else if (digit) begin
					major_d = major_x10;
				end else begin
					major_d    = major_x100;
					negative_d = 1'b0;
					minor_d    = '0;
				end
			end
		endcase

		result.valid        = step && done;
		result.version      = major_q;
		result.module_type  = type_q;
		case (type_q)
			vrp_pkg::TYPE_R: result.new_commands = 1'b1;
			vrp_pkg::TYPE_M: result.new_commands = (major_q >= min_m);
			default:         result.new_commands = (major_q >= min_p);
		endcase
		result.end_byte     = rx_byte;
	end

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= vrp_pkg::PH_MAJ_START;
			negative_q <= 1'b0;
			major_q    <= '0;
			minor_q    <= '0;
			skip_q     <= '0;
			type_q     <= vrp_pkg::TYPE_M;
		end else if (step) begin
			phase_q    <= phase_d;
			negative_q <= negative_d;
			major_q    <= major_d;
			minor_q    <= minor_d;
			skip_q     <= skip_d;
			type_q     <= type_d;
		end
	end

endmodule

FILE: rtl/vrp_out_stage.sv
// ----------------------------------------------------------------------------
// vrp_out_stage
// Result register: holds one finished reply until the master side takes it.
// ----------------------------------------------------------------------------
module vrp_out_stage (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            step,
	input  vrp_pkg::result_t                result,
	output logic                            slot_free,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [vrp_pkg::OUT_TDATA_W-1:0] m_tdata
);

	logic                            valid_q;
	logic [vrp_pkg::OUT_TDATA_W-1:0] data_q;

	assign slot_free = !valid_q || m_tready;
	assign m_tvalid  = valid_q;
	assign m_tdata   = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (step) begin
			valid_q <= result.valid;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	// Pack fields, version in the lowest bits
	always_ff @(posedge clk) begin
		if (step && result.valid) begin
			data_q <= {{(vrp_pkg::OUT_TDATA_W - vrp_pkg::OUT_FIELD_W){1'b0}},
				result.end_byte, result.new_commands, result.module_type, result.version};
		end
	end

endmodule

FILE: rtl/version_reply_parser_top.sv
// ----------------------------------------------------------------------------
// version_reply_parser_top
// Parses a serial version reply byte by byte and reports version, module type
// and whether the module supports the newer command set.
//
//   channel | dir | handshake          | payload
//   s_*     | in  | s_tvalid/s_tready  | s_tdata[7:0] = rx_byte
//   m_*     | out | m_tvalid/m_tready  | m_tdata = version, module_type,
//           |     |                    |   new_commands, end_byte, zero pad
//   cfg_*   | in  | cfg_valid/cfg_ready| cfg_index, cfg_data[15:0]
//
// One byte per cycle sustained while no result waits; m_tvalid rises once the
// ending byte has passed the input register and then the result register.
// Reset (arst_n low) clears the parser and restores both minimum versions.
// The parser stalls whenever a result waits with m_tready low; s_tready drops
// as soon as the input register is also occupied.
// cfg_ready is always high.
// ----------------------------------------------------------------------------
module version_reply_parser_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [vrp_pkg::BYTE_W-1:0]        s_tdata,   // [7:0] rx_byte
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// [15:0] version, [17:16] module_type, [18] new_commands,
	// [26:19] end_byte, [31:27] zero
	output logic [vrp_pkg::OUT_TDATA_W-1:0]   m_tdata,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [vrp_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [vrp_pkg::VER_W-1:0]         cfg_data
);

	logic                       byte_valid;
	logic [vrp_pkg::BYTE_W-1:0] rx_byte;
	logic                       slot_free;
	logic                       step;
	logic [vrp_pkg::VER_W-1:0]  min_m_q, min_p_q;
	vrp_pkg::result_t           result;

	assign step      = byte_valid && slot_free;
	assign cfg_ready = 1'b1;

	// Minimum version registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_m_q <= vrp_pkg::MIN_M_RESET;
			min_p_q <= vrp_pkg::MIN_P_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (vrp_pkg::cfg_reg_t'(cfg_index))
				vrp_pkg::REG_MIN_M: min_m_q <= cfg_data;
				vrp_pkg::REG_MIN_P: min_p_q <= cfg_data;
				default: ;
			endcase
		end
	end

	vrp_in_stage u_in (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.take       (step),
		.byte_valid (byte_valid),
		.rx_byte    (rx_byte)
	);

	vrp_parse u_parse (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.rx_byte (rx_byte),
		.min_m   (min_m_q),
		.min_p   (min_p_q),
		.result  (result)
	);

	vrp_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.result    (result),
		.slot_free (slot_free),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

endmodule

FILE: rtl/vrp_checker.sv
// ----------------------------------------------------------------------------
// vrp_checker
// Port-level checks on the version reply parser's result stream.
// ----------------------------------------------------------------------------
module vrp_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [vrp_pkg::OUT_TDATA_W-1:0] m_tdata
);

	// A stalled result holds its value
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// Only three module types exist
	a_type_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[17:16] != vrp_pkg::TYPE_W'(3))
		else $error("invalid module type");

	// R type always supports new commands
	a_r_type_new: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[17:16] == vrp_pkg::TYPE_R) |-> m_tdata[18])
		else $error("R type without new commands");

	// The ending byte is never alphanumeric
	a_end_byte: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !vrp_pkg::is_alnum(m_tdata[26:19]))
		else $error("reply ended on alphanumeric byte");

	// Pad bits stay zero
	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[vrp_pkg::OUT_TDATA_W-1:vrp_pkg::OUT_FIELD_W] == '0)
		else $error("nonzero pad bits");

endmodule

bind version_reply_parser_top vrp_checker u_vrp_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
